// ===== sv/bpdo_pkg.sv =====
package bpdo_pkg;

  // Fixed widths of the distance path.
  localparam int SUM_W          = 35;
  localparam int ROOT_W         = 18;
  localparam int TOL_W          = 8;
  localparam int COORD_BITS_DEF = 16;

  // Saturation ceiling of both squared-distance sums.
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP,
    S_LU,
    S_UL,
    S_SPAN,
    S_MIN_GO,
    S_MIN_WAIT,
    S_MAX_GO,
    S_MAX_WAIT,
    S_OUT
  } state_t;

  // Status of the square-root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// ===== sv/box_pair_distance_overlap_unit.sv =====
// Box pair distance and overlap unit.
// Two axis-aligned boxes A and B are compared one dimension per input beat.
// The input channel (in_valid, in_stall) carries both boxes' bounds on one
// axis plus last_dim, which marks the final axis of a pair. Every input beat
// yields exactly one output beat on (out_valid, out_stall) with that axis'
// intersection and union bounds. On the beat marked last_dim the output also
// carries the floor square roots of the summed squared gaps and spans, the
// containment flag and the intersect flag, with pair_done set; otherwise
// those fields are zero. The tolerance register is written on its own
// channel (cfg_valid, cfg_ready) and must only change while the unit is idle.
// One shared multiplier forms the three squares of an axis in turn, and one
// shared square-root unit resolves a root bit per cycle, both roots in turn.
// After acceptance an ordinary axis runs through the gap, LU, UL and span
// steps to the output state; a last axis also runs both roots in between.
// No new beat is accepted until the current one has been loaded into the
// output register, which takes place in the output state.
// A finished beat sits in the output register; a stalled receiver holds the
// sequencer in its output state and in_stall stays high until the beat is
// taken. Reset clears the sums, sets both flags and zeroes the tolerance.
module box_pair_distance_overlap_unit #(
  parameter int COORD_BITS = bpdo_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpdo_pkg::TOL_W-1:0]        tolerance,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      lower_a,
  input  logic signed [COORD_BITS-1:0]      upper_a,
  input  logic signed [COORD_BITS-1:0]      lower_b,
  input  logic signed [COORD_BITS-1:0]      upper_b,
  input  logic                              last_dim,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      inter_low,
  output logic signed [COORD_BITS-1:0]      inter_high,
  output logic signed [COORD_BITS-1:0]      union_low,
  output logic signed [COORD_BITS-1:0]      union_high,
  output logic [bpdo_pkg::ROOT_W-1:0]       min_dist,
  output logic [bpdo_pkg::ROOT_W-1:0]       max_dist,
  output logic                              a_contains_b,
  output logic                              boxes_intersect,
  output logic                              pair_done
);

  localparam int SUM_W = bpdo_pkg::SUM_W;
  localparam int ROOT_W = bpdo_pkg::ROOT_W;
  localparam int CW    = COORD_BITS + 3;
  localparam int MW    = COORD_BITS + 1;
  localparam int PW    = 2 * MW;
  localparam int AW    = ((SUM_W > PW) ? SUM_W : PW) + 1;

  bpdo_pkg::state_t     state;
  bpdo_pkg::state_t     state_next;
  bpdo_pkg::sqrt_stat_t sq_stat;

  logic [bpdo_pkg::TOL_W-1:0] tol;
  logic signed [COORD_BITS-1:0] la;
  logic signed [COORD_BITS-1:0] ua;
  logic signed [COORD_BITS-1:0] lb;
  logic signed [COORD_BITS-1:0] ub;
  logic                         last;
  logic [SUM_W-1:0]             gap_sum;
  logic [SUM_W-1:0]             span_sum;
  logic                         contain_so_far;
  logic                         overlap_so_far;
  logic [PW-1:0]                prod;
  logic [PW-1:0]                span_first;
  logic [ROOT_W-1:0]            min_root;
  logic [ROOT_W-1:0]            max_root;

  logic                         in_accept;
  logic                         sq_start;
  logic                         out_load;
  logic [SUM_W-1:0]             sq_value;
  logic [ROOT_W-1:0]            sq_root;

  logic signed [CW-1:0] t_pos;
  logic signed [CW-1:0] t_neg;
  logic signed [CW-1:0] d_lu;
  logic signed [CW-1:0] d_ul;
  logic signed [CW-1:0] d_bl;
  logic signed [CW-1:0] d_ll;
  logic signed [CW-1:0] d_uu;
  logic signed [CW-1:0] gap;
  logic signed [CW-1:0] mul_src;
  logic signed [CW-1:0] mul_mag;
  logic [MW-1:0]        mul_op;
  logic [PW-1:0]        prod_c;
  logic [PW-1:0]        span_pick;
  logic [PW-1:0]        add_op;
  logic [SUM_W-1:0]     add_base;
  logic [AW-1:0]        add_raw;
  logic [SUM_W-1:0]     add_sat;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol <= tolerance;
    end
  end

  // Differences of the latched bounds, all at a width that holds the tolerance too.
  assign t_pos = CW'(tol);
  assign t_neg = -t_pos;
  assign d_lu  = CW'(la) - CW'(ub);
  assign d_ul  = CW'(ua) - CW'(lb);
  assign d_bl  = CW'(lb) - CW'(ua);
  assign d_ll  = CW'(la) - CW'(lb);
  assign d_uu  = CW'(ua) - CW'(ub);

  // Signed minimum gap on this axis: zero unless a separation beats the tolerance.
  always_comb begin
    if (d_lu > t_pos) begin
      gap = d_lu;
    end else if (d_bl > t_pos) begin
      gap = d_bl;
    end else begin
      gap = '0;
    end
  end

  // Shared squarer: the sequencer picks which difference is squared this cycle.
  always_comb begin
    unique case (state)
      bpdo_pkg::S_LU: mul_src = d_lu;
      bpdo_pkg::S_UL: mul_src = d_ul;
      default:        mul_src = gap;
    endcase
    mul_mag = mul_src[CW-1] ? -mul_src : mul_src;
  end
  assign mul_op = mul_mag[MW-1:0];
  assign prod_c = mul_op * mul_op;

  // Shared saturating adder for both sums.
  assign span_pick = (span_first > prod) ? span_first : prod;
  assign add_op    = (state == bpdo_pkg::S_SPAN) ? span_pick : prod;
  assign add_base  = (state == bpdo_pkg::S_SPAN) ? span_sum : gap_sum;
  assign add_raw   = AW'(add_base) + AW'(add_op);
  assign add_sat   = (add_raw > AW'(bpdo_pkg::SUM_MAX)) ? bpdo_pkg::SUM_MAX
                                                        : add_raw[SUM_W-1:0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpdo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and control strobes.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    sq_start   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      bpdo_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = bpdo_pkg::S_GAP;
        end
      end
      bpdo_pkg::S_GAP: state_next = bpdo_pkg::S_LU;
      bpdo_pkg::S_LU:  state_next = bpdo_pkg::S_UL;
      bpdo_pkg::S_UL:  state_next = bpdo_pkg::S_SPAN;
      bpdo_pkg::S_SPAN: begin
        state_next = last ? bpdo_pkg::S_MIN_GO : bpdo_pkg::S_OUT;
      end
      bpdo_pkg::S_MIN_GO: begin
        sq_start   = 1'b1;
        state_next = bpdo_pkg::S_MIN_WAIT;
      end
      bpdo_pkg::S_MIN_WAIT: begin
        if (sq_stat.done) begin
          state_next = bpdo_pkg::S_MAX_GO;
        end
      end
      bpdo_pkg::S_MAX_GO: begin
        sq_start   = 1'b1;
        state_next = bpdo_pkg::S_MAX_WAIT;
      end
      bpdo_pkg::S_MAX_WAIT: begin
        if (sq_stat.done) begin
          state_next = bpdo_pkg::S_OUT;
        end
      end
      bpdo_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = bpdo_pkg::S_IDLE;
        end
      end
      default: state_next = bpdo_pkg::S_IDLE;
    endcase
  end

  // Input capture, squares and root results.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      la   <= lower_a;
      ua   <= upper_a;
      lb   <= lower_b;
      ub   <= upper_b;
      last <= last_dim;
    end
    if (state == bpdo_pkg::S_GAP || state == bpdo_pkg::S_LU ||
        state == bpdo_pkg::S_UL) begin
      prod <= prod_c;
    end
    if (state == bpdo_pkg::S_UL) begin
      span_first <= prod;
    end
    if (state == bpdo_pkg::S_MIN_WAIT && sq_stat.done) begin
      min_root <= sq_root;
    end
    if (state == bpdo_pkg::S_MAX_WAIT && sq_stat.done) begin
      max_root <= sq_root;
    end
  end

  // Accumulated pair state; cleared once the last axis is loaded into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_sum        <= '0;
      span_sum       <= '0;
      contain_so_far <= 1'b1;
      overlap_so_far <= 1'b1;
    end else begin
      if (state == bpdo_pkg::S_GAP) begin
        if (d_ll > t_pos || d_uu < t_neg) begin
          contain_so_far <= 1'b0;
        end
        if (d_lu > t_pos || d_ul < t_neg) begin
          overlap_so_far <= 1'b0;
        end
      end
      if (state == bpdo_pkg::S_LU) begin
        gap_sum <= add_sat;
      end
      if (state == bpdo_pkg::S_SPAN) begin
        span_sum <= add_sat;
      end
      if (out_load && last) begin
        gap_sum        <= '0;
        span_sum       <= '0;
        contain_so_far <= 1'b1;
        overlap_so_far <= 1'b1;
      end
    end
  end

  // Output register: valid flag under reset, payload loaded with each beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inter_low       <= (la > lb) ? la : lb;
      inter_high      <= (ua < ub) ? ua : ub;
      union_low       <= (la < lb) ? la : lb;
      union_high      <= (ua > ub) ? ua : ub;
      min_dist        <= last ? min_root : '0;
      max_dist        <= last ? max_root : '0;
      a_contains_b    <= last && contain_so_far;
      boxes_intersect <= last && overlap_so_far && !contain_so_far;
      pair_done       <= last;
    end
  end

  // Square-root unit, shared by both distances.
  assign sq_value = (state == bpdo_pkg::S_MIN_GO) ? gap_sum : span_sum;

  bpdo_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .root  (sq_root),
    .stat  (sq_stat)
  );

  // An accepted beat always starts with the gap square.
  a_accept_to_gap: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == bpdo_pkg::S_GAP)
    else $error("accepted beat did not enter the gap step");

  // The root unit is never restarted while it is still working.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_stat.busy)
    else $error("square-root unit started while busy");

  // A finished root only arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> (state == bpdo_pkg::S_MIN_WAIT || state == bpdo_pkg::S_MAX_WAIT))
    else $error("root finished outside a wait state");

  // Beats that do not close a pair carry no pair results.
  a_open_pair_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pair_done) |->
      (min_dist == '0 && max_dist == '0 && !a_contains_b && !boxes_intersect))
    else $error("pair result fields set before the last axis");

  // Containment and intersection are reported exclusively.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(a_contains_b && boxes_intersect))
    else $error("containment and intersection both set");

endmodule

// ===== sv/bpdo_isqrt.sv =====
module bpdo_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bpdo_pkg::SUM_W-1:0]     value,
  output logic [bpdo_pkg::ROOT_W-1:0]    root,
  output bpdo_pkg::sqrt_stat_t           stat
);

  localparam int ROOT_W = bpdo_pkg::ROOT_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // One restoring step: bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  // Control: busy while the root bits are resolved, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: radicand shift, partial remainder and root.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(value);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
